>>> design/pac_pkg.sv
// Shared types, constants and the divider step for the premultiplied alpha codec.
`default_nettype none

package pac_pkg;

    // Field widths
    localparam int COLOR_W = 16;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;

    // Stream payload widths
    localparam int S_DATA_W = 4 * COLOR_W + WORD_W;
    localparam int M_DATA_W = WORD_W + 4 * COLOR_W;

    // Lane and pipeline shape
    localparam int LANES       = 3;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = COLOR_W / DIV_STEPS;
    localparam int LANE_STAGES = 2 + DIV_STAGES;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    // Luminance weights and reciprocal of 100 (exact for sums below 2**23)
    localparam int SUM_W     = 23;
    localparam int RECIP_W   = 24;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [SUM_W-1:0]   LUM_W_R   = 23'd30;
    localparam logic [SUM_W-1:0]   LUM_W_G   = 23'd59;
    localparam logic [SUM_W-1:0]   LUM_W_B   = 23'd11;
    localparam logic [SUM_W-1:0]   LUM_BIAS  = 23'd50;
    localparam logic [RECIP_W-1:0] LUM_RECIP = 24'd10737419;
    localparam int                 LUM_SHIFT = 30;

    // Premultiply rounding and full scale
    localparam int PMUL_W = 24;
    localparam logic [PMUL_W-1:0]  PREMUL_BIAS = 24'd32767;
    localparam logic [COLOR_W:0]   FULL_SCALE  = 17'd65535;
    localparam logic [BYTE_W-1:0]  OPAQUE      = 8'hff;
    localparam logic [COLOR_W-1:0] SAT_VALUE   = 16'hffff;

    typedef enum logic {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } t_func;

    // Lane operand set
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [BYTE_W-1:0]  dbyte;
        logic [BYTE_W-1:0]  alpha;
        logic               use_lum;
    } t_lane_in;

    // Lane results
    typedef struct packed {
        logic [BYTE_W-1:0]  enc;
        logic [COLOR_W-1:0] dec;
    } t_lane_out;

    // Restoring divider state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [BYTE_W-1:0]  rem;
        logic [COLOR_W-1:0] qd;
    } t_div;

    // Decode special cases
    typedef struct packed {
        logic opq;
        logic zero;
        logic sat;
    } t_dflag;

    // Per-stage control carried beside the lanes
    typedef struct packed {
        t_func             func;
        logic              gray;
        logic [BYTE_W-1:0] alpha;
    } t_ctl;

    // One quotient bit of the restoring division
    function automatic t_div div_step(t_div d, logic [BYTE_W-1:0] dvs);
        logic [BYTE_W:0] t;
        t_div            q;
        t    = {d.rem, d.qd[COLOR_W-1]};
        q.qd = {d.qd[COLOR_W-2:0], 1'b0};
        if (t >= {1'b0, dvs}) begin
            q.rem   = BYTE_W'(t - {1'b0, dvs});
            q.qd[0] = 1'b1;
        end else begin
            q.rem = t[BYTE_W-1:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

>>> design/pac_luma.sv
// Luminance unit: weighted sum, then division by 100 through a reciprocal multiply.
`default_nettype none

module pac_luma (
    input  wire logic                         i_clk,
    input  wire logic [1:0]                   i_en,
    input  wire logic [pac_pkg::COLOR_W-1:0]  i_red,
    input  wire logic [pac_pkg::COLOR_W-1:0]  i_green,
    input  wire logic [pac_pkg::COLOR_W-1:0]  i_blue,
    output logic      [pac_pkg::COLOR_W-1:0]  o_lum
);
    import pac_pkg::*;

    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [PROD_W-1:0]  n_prod;
    logic [COLOR_W-1:0] r_lum;

    // Weighted sum with rounding bias
    assign n_sum = SUM_W'(i_red) * LUM_W_R + SUM_W'(i_green) * LUM_W_G
                 + SUM_W'(i_blue) * LUM_W_B + LUM_BIAS;

    // Divide by 100
    assign n_prod = PROD_W'(r_sum) * PROD_W'(LUM_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum <= n_sum;
        end
        if (i_en[1]) begin
            r_lum <= n_prod[LUM_SHIFT +: COLOR_W];
        end
    end

    assign o_lum = r_lum;

endmodule

`default_nettype wire

>>> design/pac_lane.sv
// One color lane: premultiply for encode, pipelined division by alpha for decode.
`default_nettype none

module pac_lane (
    input  wire logic                            i_clk,
    input  wire logic [pac_pkg::LANE_STAGES-1:0] i_en,
    input  wire pac_pkg::t_lane_in               i_data,
    input  wire logic [pac_pkg::COLOR_W-1:0]     i_lum,
    output pac_pkg::t_lane_out                   o_data
);
    import pac_pkg::*;

    // Input stage
    logic [COLOR_W-1:0] r0_color;
    logic [BYTE_W-1:0]  r0_dbyte;
    logic [BYTE_W-1:0]  r0_alpha;
    logic               r0_use_lum;

    // Encode path
    logic [COLOR_W-1:0] r1_color;
    logic               r1_use_lum;
    logic [COLOR_W-1:0] c_sel;
    logic [PMUL_W-1:0]  n2_prod;
    logic [PMUL_W-1:0]  r2_prod;
    logic [BYTE_W-1:0]  r2_hi;
    logic               r2_opq;
    logic [BYTE_W-1:0]  q0;
    logic [COLOR_W:0]   rem65535;
    logic [BYTE_W-1:0]  n3_enc;
    logic [BYTE_W-1:0]  r_enc [DIV_STAGES-1];

    // Decode path, index 0 is the prep stage
    logic [PMUL_W-1:0]  n1_num;
    t_div               n1_div;
    t_dflag             n1_flg;
    t_div               r_div [DIV_STAGES+1];
    t_dflag             r_flg [DIV_STAGES+1];
    logic [BYTE_W-1:0]  r_a   [DIV_STAGES+1];
    logic [BYTE_W-1:0]  r_b   [DIV_STAGES+1];
    t_div               n_div [1:DIV_STAGES];

    // Capture operands
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_color   <= i_data.color;
            r0_dbyte   <= i_data.dbyte;
            r0_alpha   <= i_data.alpha;
            r0_use_lum <= i_data.use_lum;
        end
    end

    // Build dividend b*65535 + a/2 and sort out the special cases
    assign n1_num     = {r0_dbyte, 16'b0} - PMUL_W'(r0_dbyte) + PMUL_W'(r0_alpha >> 1);
    assign n1_div.rem = n1_num[PMUL_W-1 -: BYTE_W];
    assign n1_div.qd  = n1_num[COLOR_W-1:0];
    assign n1_flg.opq  = (r0_alpha == OPAQUE);
    assign n1_flg.zero = (r0_alpha == '0);
    assign n1_flg.sat  = (n1_num[PMUL_W-1 -: BYTE_W] >= r0_alpha);

    // Premultiply product with rounding bias
    assign c_sel   = r1_use_lum ? i_lum : r1_color;
    assign n2_prod = PMUL_W'(c_sel) * PMUL_W'(r_a[0]) + PREMUL_BIAS;

    // Divide by 65535: estimate from the high part, one correction
    assign q0       = r2_prod[PMUL_W-1 -: BYTE_W];
    assign rem65535 = (COLOR_W+1)'(r2_prod[COLOR_W-1:0]) + (COLOR_W+1)'(q0);
    assign n3_enc   = r2_opq ? r2_hi
                    : ((rem65535 >= FULL_SCALE) ? BYTE_W'(q0 + 8'd1) : q0);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_color   <= r0_color;
            r1_use_lum <= r0_use_lum;
        end
        if (i_en[2]) begin
            r2_prod <= n2_prod;
            r2_hi   <= c_sel[COLOR_W-1 -: BYTE_W];
            r2_opq  <= r_flg[0].opq;
        end
        if (i_en[3]) begin
            r_enc[0] <= n3_enc;
        end
        for (int k = 1; k < DIV_STAGES - 1; k++) begin
            if (i_en[3+k]) begin
                r_enc[k] <= r_enc[k-1];
            end
        end
    end

    // Division steps, a fixed group per stage
    always_comb begin
        for (int j = 1; j <= DIV_STAGES; j++) begin
            n_div[j] = r_div[j-1];
            for (int s = 0; s < DIV_STEPS; s++) begin
                n_div[j] = div_step(n_div[j], r_a[j-1]);
            end
        end
    end

    // Advance the division pipeline
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_div[0] <= n1_div;
            r_flg[0] <= n1_flg;
            r_a[0]   <= r0_alpha;
            r_b[0]   <= r0_dbyte;
        end
        for (int j = 1; j <= DIV_STAGES; j++) begin
            if (i_en[1+j]) begin
                r_div[j] <= n_div[j];
                r_flg[j] <= r_flg[j-1];
                r_a[j]   <= r_a[j-1];
                r_b[j]   <= r_b[j-1];
            end
        end
    end

    // Pick the decoded value
    always_comb begin
        o_data.enc = r_enc[DIV_STAGES-2];
        if (r_flg[DIV_STAGES].opq) begin
            o_data.dec = {r_b[DIV_STAGES], r_b[DIV_STAGES]};
        end else if (r_flg[DIV_STAGES].zero) begin
            o_data.dec = '0;
        end else if (r_flg[DIV_STAGES].sat) begin
            o_data.dec = SAT_VALUE;
        end else begin
            o_data.dec = r_div[DIV_STAGES].qd;
        end
    end

endmodule

`default_nettype wire

>>> design/premultiplied_alpha_color_codec_unit.sv
// Top level of the premultiplied alpha codec: lanes, luminance unit, merge and handshake.
//
//  Channel        | Direction | Transaction
//  ---------------+-----------+----------------------------------------------------
//  s_axis_*       | in        | tuser func; tdata red, green, blue, alpha, word
//  m_axis_*       | out       | tdata word, red, green, blue, alpha
//  i_cfg_*        | in        | write of gray_mode, taken on any edge with i_cfg_we
//
// One transaction per cycle is accepted while s_axis_tready is high. The accepting
// edge loads the first of seven register stages: six lane stages (four of them the
// 16-step alpha divider), then the output register, which drives m_axis_tvalid.
// Reset clears the stage valid bits and gray_mode; payload registers are not reset.
// Each stage loads when it is empty or its content moves on, so bubbles close up while
// m_axis_tready is low and s_axis_tready drops only when every stage is full.
`default_nettype none

module premultiplied_alpha_color_codec_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] red_in, [31:16] green_in, [47:32] blue_in, [63:48] alpha_in, [95:64] word_in
    input  wire logic [pac_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic                          s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [31:0] word_out, [47:32] red_out, [63:48] green_out, [79:64] blue_out,
    // [95:80] alpha_out
    output logic      [pac_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import pac_pkg::*;

    logic                r_gray_mode;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES:0]   en;
    t_ctl                r_ctl [LANE_STAGES];
    t_ctl                n_ctl;

    logic [COLOR_W-1:0]  in_red;
    logic [COLOR_W-1:0]  in_green;
    logic [COLOR_W-1:0]  in_blue;
    logic [COLOR_W-1:0]  in_alpha;
    logic [WORD_W-1:0]   in_word;
    logic [COLOR_W-1:0]  lum;

    t_lane_in            lane_in  [LANES];
    t_lane_out           lane_out [LANES];

    logic [WORD_W-1:0]   r_word;
    logic [COLOR_W-1:0]  r_red;
    logic [COLOR_W-1:0]  r_green;
    logic [COLOR_W-1:0]  r_blue;
    logic [COLOR_W-1:0]  r_alpha;

    // Unpack the input transaction
    assign in_red   = s_axis_tdata[0*COLOR_W +: COLOR_W];
    assign in_green = s_axis_tdata[1*COLOR_W +: COLOR_W];
    assign in_blue  = s_axis_tdata[2*COLOR_W +: COLOR_W];
    assign in_alpha = s_axis_tdata[3*COLOR_W +: COLOR_W];
    assign in_word  = s_axis_tdata[4*COLOR_W +: WORD_W];

    assign n_ctl.func  = t_func'(s_axis_tuser);
    assign n_ctl.gray  = r_gray_mode;
    assign n_ctl.alpha = (t_func'(s_axis_tuser) == FUNC_DECODE)
                       ? in_word[BYTE_W-1:0] : in_alpha[COLOR_W-1 -: BYTE_W];

    // Hold the gray mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_gray_mode <= i_cfg_wdata;
        end
    end

    // Stage enables: load when empty or when the content moves on
    always_comb begin
        en[PIPE_STAGES] = m_axis_tready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[PIPE_STAGES-1];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Carry per-transaction control beside the lanes
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ctl[0] <= n_ctl;
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (en[k]) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // Lane operands
    always_comb begin
        lane_in[0].color   = in_red;
        lane_in[0].dbyte   = r_gray_mode ? in_word[15:8] : in_word[31:24];
        lane_in[0].alpha   = n_ctl.alpha;
        lane_in[0].use_lum = r_gray_mode;
        lane_in[1].color   = in_green;
        lane_in[1].dbyte   = in_word[23:16];
        lane_in[1].alpha   = n_ctl.alpha;
        lane_in[1].use_lum = 1'b0;
        lane_in[2].color   = in_blue;
        lane_in[2].dbyte   = in_word[15:8];
        lane_in[2].alpha   = n_ctl.alpha;
        lane_in[2].use_lum = 1'b0;
    end

    pac_luma u_luma (
        .i_clk   (i_clk),
        .i_en    (en[1:0]),
        .i_red   (in_red),
        .i_green (in_green),
        .i_blue  (in_blue),
        .o_lum   (lum)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        pac_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en[LANE_STAGES-1:0]),
            .i_data (lane_in[l]),
            .i_lum  (lum),
            .o_data (lane_out[l])
        );
    end

    // Merge lane results into the output transaction
    always_ff @(posedge i_clk) begin
        if (en[PIPE_STAGES-1]) begin
            if (r_ctl[LANE_STAGES-1].func == FUNC_DECODE) begin
                r_word  <= '0;
                r_red   <= lane_out[0].dec;
                r_green <= r_ctl[LANE_STAGES-1].gray ? lane_out[0].dec : lane_out[1].dec;
                r_blue  <= r_ctl[LANE_STAGES-1].gray ? lane_out[0].dec : lane_out[2].dec;
                r_alpha <= {r_ctl[LANE_STAGES-1].alpha, r_ctl[LANE_STAGES-1].alpha};
            end else begin
                if (r_ctl[LANE_STAGES-1].gray) begin
                    r_word <= {16'b0, lane_out[0].enc, r_ctl[LANE_STAGES-1].alpha};
                end else begin
                    r_word <= {lane_out[0].enc, lane_out[1].enc, lane_out[2].enc,
                               r_ctl[LANE_STAGES-1].alpha};
                end
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
                r_alpha <= '0;
            end
        end
    end

    assign m_axis_tdata = {r_alpha, r_blue, r_green, r_red, r_word};

endmodule

`default_nettype wire
